>>> sv/lens_distortion_coordinate_map_macros.svh
// Assertion helpers used by the checker file.
`ifndef LENS_DISTORTION_COORDINATE_MAP_MACROS_SVH
`define LENS_DISTORTION_COORDINATE_MAP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define LDCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ldcm assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define LDCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ldcm assertion failed");

`endif

>>> sv/ldcm_pkg.sv
`timescale 1ns / 1ps
package ldcm_pkg;

  // Beat payloads
  typedef struct packed {
    logic [9:0] out_col;
    logic [8:0] out_row;
  } in_t;

  typedef struct packed {
    logic [9:0] src_col;
    logic [8:0] src_row;
    logic       in_range;
  } out_t;

  // Register indexes
  localparam logic [2:0] REG_FOCAL = 3'd0;
  localparam logic [2:0] REG_PP    = 3'd1;
  localparam logic [2:0] REG_SKEW  = 3'd2;
  localparam logic [2:0] REG_K1    = 3'd3;
  localparam logic [2:0] REG_K2    = 3'd4;
  localparam logic [2:0] REG_K3    = 3'd5;
  localparam logic [2:0] REG_P1    = 3'd6;
  localparam logic [2:0] REG_P2    = 3'd7;

  localparam logic [63:0] FOCAL_RESET = 64'h0000_0001_0000_0001 << 16;

  localparam int DEF_IMAGE_WIDTH  = 640;
  localparam int DEF_IMAGE_HEIGHT = 480;

  // Divider: quotient bits resolved one per stage
  localparam int DIV_STEPS = 33;

  localparam logic signed [31:0] Q24_ONE = 32'sh0100_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'(S32_MAX)) return S32_MAX;
    if (v < 72'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  // Floor a Q8.24 product back to Q8.24
  function automatic logic signed [31:0] shsat24(input logic signed [63:0] p);
    return sat32(72'(p >>> 24));
  endfunction

  // Floor a Q4.28 x Q8.24 product back to Q8.24
  function automatic logic signed [31:0] shsat28(input logic signed [63:0] p);
    return sat32(72'(p >>> 28));
  endfunction

endpackage

>>> sv/ldcm_div.sv
`timescale 1ns / 1ps
// Pipelined floor division (num << 24) / den, saturated to 32 bits signed.
module ldcm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [33:0]  in_num,
  input  logic        [31:0]  den,
  output logic                out_vld,
  output logic signed [31:0]  out_q
);

  localparam int N = ldcm_pkg::DIV_STEPS;

  logic        v_r   [0:N];
  logic        neg_r [0:N];
  logic        ovf_r [0:N];
  logic [31:0] rem_r [0:N];
  logic [32:0] low_r [0:N];
  logic [32:0] q_r   [0:N];

  logic [32:0] mag;
  logic               out_vld_r;
  logic signed [31:0] out_q_r;

  assign mag = in_num[33] ? 33'(-in_num) : in_num[32:0];

  // Setup: catch quotients of 2^33 and up, seed the partial remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= in_num[33];
      ovf_r[0] <= 32'(mag[32:9]) >= den;
      rem_r[0] <= 32'(mag[32:9]);
      low_r[0] <= {mag[8:0], 24'd0};
      q_r[0]   <= '0;
    end
  end

  // One quotient bit per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [32:0] rem2;
    logic [33:0] dif;
    logic        ge;

    assign rem2 = {rem_r[i], low_r[i][32]};
    assign dif  = 34'(rem2) - 34'(den);
    assign ge   = !dif[33];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
        rem_r[i+1] <= ge ? dif[31:0] : rem2[31:0];
        low_r[i+1] <= {low_r[i][31:0], 1'b0};
        q_r[i+1]   <= {q_r[i][31:0], ge};
      end
    end
  end

  // Round toward minus infinity and clamp
  logic [33:0]        qq;
  logic signed [31:0] q_nxt;

  always_comb begin
    qq = 34'(q_r[N]) + 34'(rem_r[N] != '0);
    if (!neg_r[N]) begin
      if (ovf_r[N] || q_r[N][32:31] != 2'b00) q_nxt = ldcm_pkg::S32_MAX;
      else q_nxt = $signed({1'b0, q_r[N][30:0]});
    end else begin
      if (ovf_r[N] || qq > 34'h0_8000_0000) q_nxt = ldcm_pkg::S32_MIN;
      else q_nxt = $signed(~qq[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q_r <= q_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_q   = out_q_r;

endmodule

>>> sv/lens_distortion_coordinate_map.sv
`timescale 1ns / 1ps
// Brown-Conrady coordinate remap: for each output pixel beat (out_col, out_row) it returns
// the floored source pixel and an in-range flag. One beat is accepted per clock unless the
// whole pipe holds while a result waits on out_ready; results leave in order via the two
// 33-stage normalizing dividers (one quotient bit per stage) and the 16-stage multiply
// chain. Write registers through cfg_we/cfg_addr/cfg_wdata only while the pipe is empty; the
// block does not enforce it. A zero focal length forces a zero, out-of-range result.
module lens_distortion_coordinate_map #(
  parameter int IMAGE_WIDTH  = ldcm_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ldcm_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ldcm_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ldcm_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [63:0]          cfg_wdata
);

  // Configuration registers
  logic [63:0]        focal_r, pp_r;
  logic signed [31:0] skew_r, k1_r, k2_r, k3_r, p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= ldcm_pkg::FOCAL_RESET;
      pp_r    <= '0;
      skew_r  <= '0;
      k1_r    <= '0;
      k2_r    <= '0;
      k3_r    <= '0;
      p1_r    <= '0;
      p2_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ldcm_pkg::REG_FOCAL: focal_r <= cfg_wdata;
        ldcm_pkg::REG_PP:    pp_r    <= cfg_wdata;
        ldcm_pkg::REG_SKEW:  skew_r  <= $signed(cfg_wdata[31:0]);
        ldcm_pkg::REG_K1:    k1_r    <= $signed(cfg_wdata[31:0]);
        ldcm_pkg::REG_K2:    k2_r    <= $signed(cfg_wdata[31:0]);
        ldcm_pkg::REG_K3:    k3_r    <= $signed(cfg_wdata[31:0]);
        ldcm_pkg::REG_P1:    p1_r    <= $signed(cfg_wdata[31:0]);
        ldcm_pkg::REG_P2:    p2_r    <= $signed(cfg_wdata[31:0]);
        default: ;
      endcase
    end
  end

  logic [31:0] fx, fy, cx, cy;
  assign fx = focal_r[63:32];
  assign fy = focal_r[31:0];
  assign cx = pp_r[63:32];
  assign cy = pp_r[31:0];

  // Global advance: hold everything while a result is stalled
  logic en;
  logic out_valid_r;
  ldcm_pkg::out_t out_data_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Input stage: offset from the principal point in Q16.16
  logic               s0_v_r;
  logic signed [33:0] s0_dx_r, s0_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r <= $signed({8'd0, in_data.out_col, 16'd0}) - $signed({2'b0, cx});
      s0_dy_r <= $signed({9'd0, in_data.out_row, 16'd0}) - $signed({2'b0, cy});
    end
  end

  // Normalize both axes
  logic               dvx_v, dvy_v;
  logic signed [31:0] dvx_q, dvy_q;

  ldcm_div u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s0_v_r),
    .in_num (s0_dx_r),
    .den    (fx),
    .out_vld(dvx_v),
    .out_q  (dvx_q)
  );

  ldcm_div u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (s0_v_r),
    .in_num (s0_dy_r),
    .den    (fy),
    .out_vld(dvy_v),
    .out_q  (dvy_q)
  );

  // Valid line for the multiply chain
  logic v_r [1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 16; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= dvx_v && dvy_v;
      for (int i = 2; i <= 16; i++) v_r[i] <= v_r[i-1];
    end
  end

  logic signed [31:0] e1_x_r, e1_y_r;
  logic signed [63:0] e1_p_r;
  logic signed [31:0] e2_x_r, e2_y_r;
  logic signed [63:0] e3_pxx_r, e3_pyy_r, e3_pxy_r;
  logic signed [31:0] e3_x_r, e3_y_r;
  logic signed [31:0] e4_xx_r, e4_yy_r, e4_xy_r, e4_r2_r, e4_x_r, e4_y_r;
  logic signed [63:0] e5_pr4_r, e5_pk1_r;
  logic signed [31:0] e5_r2_r, e5_ax_r, e5_ay_r, e5_xy_r, e5_x_r, e5_y_r;
  logic signed [31:0] e6_r4_r, e6_t1_r, e6_r2_r, e6_ax_r, e6_ay_r, e6_xy_r, e6_x_r, e6_y_r;
  logic signed [63:0] e7_pr6_r, e7_pk2_r;
  logic signed [31:0] e7_t1_r, e7_ax_r, e7_ay_r, e7_xy_r, e7_x_r, e7_y_r;
  logic signed [31:0] e8_r6_r, e8_t1_r, e8_t2_r, e8_ax_r, e8_ay_r, e8_xy_r, e8_x_r, e8_y_r;
  logic signed [63:0] e9_pk3_r;
  logic signed [31:0] e9_t1_r, e9_t2_r, e9_ax_r, e9_ay_r, e9_xy_r, e9_x_r, e9_y_r;
  logic signed [31:0] e10_rad_r, e10_ax_r, e10_ay_r, e10_xy_r, e10_x_r, e10_y_r;
  logic signed [63:0] e11_pxr_r, e11_pyr_r, e11_a_r, e11_b_r, e11_c_r, e11_d_r;
  logic signed [31:0] e12_xd_r, e12_yd_r;
  logic signed [63:0] e13_psk_r;
  logic signed [31:0] e13_xd_r, e13_yd_r;
  logic signed [31:0] e14_s_r, e14_yd_r;
  logic signed [64:0] e15_pu_r, e15_pv_r;
  logic signed [65:0] e16_u_r, e16_v_r;

  // Distortion chain: each product is registered before it is floored
  always_ff @(posedge clk) begin
    if (en) begin
      // skew correction
      e1_x_r <= dvx_q;
      e1_y_r <= dvy_q;
      e1_p_r <= skew_r * dvy_q;
      e2_x_r <= ldcm_pkg::sat32(72'(e1_x_r) - 72'(ldcm_pkg::shsat28(e1_p_r)));
      e2_y_r <= e1_y_r;
      // squares
      e3_pxx_r <= e2_x_r * e2_x_r;
      e3_pyy_r <= e2_y_r * e2_y_r;
      e3_pxy_r <= e2_x_r * e2_y_r;
      e3_x_r   <= e2_x_r;
      e3_y_r   <= e2_y_r;
      e4_xx_r  <= ldcm_pkg::shsat24(e3_pxx_r);
      e4_yy_r  <= ldcm_pkg::shsat24(e3_pyy_r);
      e4_xy_r  <= ldcm_pkg::shsat24(e3_pxy_r);
      e4_r2_r  <= ldcm_pkg::sat32(72'(ldcm_pkg::shsat24(e3_pxx_r))
                                  + 72'(ldcm_pkg::shsat24(e3_pyy_r)));
      e4_x_r   <= e3_x_r;
      e4_y_r   <= e3_y_r;
      // radial powers and terms
      e5_pr4_r <= e4_r2_r * e4_r2_r;
      e5_pk1_r <= k1_r * e4_r2_r;
      e5_r2_r  <= e4_r2_r;
      e5_ax_r  <= ldcm_pkg::sat32(72'(e4_r2_r) + (72'(e4_xx_r) <<< 1));
      e5_ay_r  <= ldcm_pkg::sat32(72'(e4_r2_r) + (72'(e4_yy_r) <<< 1));
      e5_xy_r  <= e4_xy_r;
      e5_x_r   <= e4_x_r;
      e5_y_r   <= e4_y_r;
      e6_r4_r  <= ldcm_pkg::shsat24(e5_pr4_r);
      e6_t1_r  <= ldcm_pkg::shsat28(e5_pk1_r);
      e6_r2_r  <= e5_r2_r;
      e6_ax_r  <= e5_ax_r;
      e6_ay_r  <= e5_ay_r;
      e6_xy_r  <= e5_xy_r;
      e6_x_r   <= e5_x_r;
      e6_y_r   <= e5_y_r;
      e7_pr6_r <= e6_r4_r * e6_r2_r;
      e7_pk2_r <= k2_r * e6_r4_r;
      e7_t1_r  <= e6_t1_r;
      e7_ax_r  <= e6_ax_r;
      e7_ay_r  <= e6_ay_r;
      e7_xy_r  <= e6_xy_r;
      e7_x_r   <= e6_x_r;
      e7_y_r   <= e6_y_r;
      e8_r6_r  <= ldcm_pkg::shsat24(e7_pr6_r);
      e8_t1_r  <= e7_t1_r;
      e8_t2_r  <= ldcm_pkg::shsat28(e7_pk2_r);
      e8_ax_r  <= e7_ax_r;
      e8_ay_r  <= e7_ay_r;
      e8_xy_r  <= e7_xy_r;
      e8_x_r   <= e7_x_r;
      e8_y_r   <= e7_y_r;
      e9_pk3_r <= k3_r * e8_r6_r;
      e9_t1_r  <= e8_t1_r;
      e9_t2_r  <= e8_t2_r;
      e9_ax_r  <= e8_ax_r;
      e9_ay_r  <= e8_ay_r;
      e9_xy_r  <= e8_xy_r;
      e9_x_r   <= e8_x_r;
      e9_y_r   <= e8_y_r;
      e10_rad_r <= ldcm_pkg::sat32(72'(ldcm_pkg::Q24_ONE) + 72'(e9_t1_r) + 72'(e9_t2_r)
                                   + 72'(ldcm_pkg::shsat28(e9_pk3_r)));
      e10_ax_r <= e9_ax_r;
      e10_ay_r <= e9_ay_r;
      e10_xy_r <= e9_xy_r;
      e10_x_r  <= e9_x_r;
      e10_y_r  <= e9_y_r;
      // tangential terms
      e11_pxr_r <= e10_x_r * e10_rad_r;
      e11_pyr_r <= e10_y_r * e10_rad_r;
      e11_a_r   <= p1_r * e10_xy_r;
      e11_b_r   <= p2_r * e10_ax_r;
      e11_c_r   <= p1_r * e10_ay_r;
      e11_d_r   <= p2_r * e10_xy_r;
      e12_xd_r  <= ldcm_pkg::sat32(72'(ldcm_pkg::shsat24(e11_pxr_r))
                                   + (72'(ldcm_pkg::shsat28(e11_a_r)) <<< 1)
                                   + 72'(ldcm_pkg::shsat28(e11_b_r)));
      e12_yd_r  <= ldcm_pkg::sat32(72'(ldcm_pkg::shsat24(e11_pyr_r))
                                   + 72'(ldcm_pkg::shsat28(e11_c_r))
                                   + (72'(ldcm_pkg::shsat28(e11_d_r)) <<< 1));
      // re-apply skew and project
      e13_psk_r <= skew_r * e12_yd_r;
      e13_xd_r  <= e12_xd_r;
      e13_yd_r  <= e12_yd_r;
      e14_s_r   <= ldcm_pkg::sat32(72'(e13_xd_r) + 72'(ldcm_pkg::shsat28(e13_psk_r)));
      e14_yd_r  <= e13_yd_r;
      e15_pu_r  <= $signed({1'b0, fx}) * e14_s_r;
      e15_pv_r  <= $signed({1'b0, fy}) * e14_yd_r;
      e16_u_r   <= 66'(e15_pu_r >>> 24) + $signed({34'd0, cx});
      e16_v_r   <= 66'(e15_pv_r >>> 24) + $signed({34'd0, cy});
    end
  end

  // Floor to pixels and check bounds
  logic           col_ok, row_ok, zero_f;
  ldcm_pkg::out_t res_nxt;

  always_comb begin
    zero_f = (fx == '0) || (fy == '0);
    col_ok = !e16_u_r[65] && (e16_u_r[65:16] < 50'(IMAGE_WIDTH));
    row_ok = !e16_v_r[65] && (e16_v_r[65:16] < 50'(IMAGE_HEIGHT));
    res_nxt = '0;
    if (col_ok && row_ok && !zero_f) begin
      res_nxt.src_col  = e16_u_r[25:16];
      res_nxt.src_row  = e16_v_r[24:16];
      res_nxt.in_range = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/ldcm_chk.sv
`timescale 1ns / 1ps
`include "lens_distortion_coordinate_map_macros.svh"
// Port-level checks on the remap block.
module ldcm_chk #(
  parameter int IMAGE_WIDTH  = ldcm_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = ldcm_pkg::DEF_IMAGE_HEIGHT
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ldcm_pkg::out_t out_data
);

  // Hold a stalled result
  `LDCM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Never back-pressure while the output is empty
  `LDCM_ASSERT_IMP(a_ready_empty, !out_valid, in_ready)

  // Out-of-range results carry zero coordinates
  `LDCM_ASSERT_IMP(a_zero_oor, out_valid && !out_data.in_range,
                   out_data.src_col == '0 && out_data.src_row == '0)

  // In-range results lie inside the image
  `LDCM_ASSERT_IMP(a_in_bounds, out_valid && out_data.in_range,
                   32'(out_data.src_col) < IMAGE_WIDTH && 32'(out_data.src_row) < IMAGE_HEIGHT)

endmodule

bind lens_distortion_coordinate_map ldcm_chk #(
  .IMAGE_WIDTH (IMAGE_WIDTH),
  .IMAGE_HEIGHT(IMAGE_HEIGHT)
) u_ldcm_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> test/tb_lens_distortion_coordinate_map.sv
`timescale 1ns / 1ps
module tb_lens_distortion_coordinate_map;

  localparam int PIPE_DEPTH = 53;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ldcm_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  ldcm_pkg::out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [63:0] cfg_wdata;

  // Shadow copy of the register file
  logic [63:0] shadow_reg [8];
  ldcm_pkg::out_t pending_coords [$];
  int fails;
  int cycles;
  bit quiet;

  // One directed beat: input and, where obvious, the typed-in result
  typedef struct {
    int col;
    int row;
    bit fixed;
    ldcm_pkg::out_t want;
  } pix_row_t;

  lens_distortion_coordinate_map DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp to the signed 32-bit range
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Floored, clamped product
  function automatic longint qmul(longint a, longint b, int sh);
    return clamp32((a * b) >>> sh);
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic longint as_s32(logic [63:0] r);
    return longint'($signed(r[31:0]));
  endfunction

  // Map an output pixel to its distorted source pixel
  function automatic ldcm_pkg::out_t remap_pixel(ldcm_pkg::in_t d);
    longint fx, fy, cx, cy, skew, k1, k2, k3, p1, p2;
    longint px, py, x, y, xx, yy, xy, r2, r4, r6, rad, xd, yd, s, u, v, col, row;
    ldcm_pkg::out_t res;
    fx = longint'(shadow_reg[ldcm_pkg::REG_FOCAL][63:32]);
    fy = longint'(shadow_reg[ldcm_pkg::REG_FOCAL][31:0]);
    cx = longint'(shadow_reg[ldcm_pkg::REG_PP][63:32]);
    cy = longint'(shadow_reg[ldcm_pkg::REG_PP][31:0]);
    skew = as_s32(shadow_reg[ldcm_pkg::REG_SKEW]);
    k1 = as_s32(shadow_reg[ldcm_pkg::REG_K1]);
    k2 = as_s32(shadow_reg[ldcm_pkg::REG_K2]);
    k3 = as_s32(shadow_reg[ldcm_pkg::REG_K3]);
    p1 = as_s32(shadow_reg[ldcm_pkg::REG_P1]);
    p2 = as_s32(shadow_reg[ldcm_pkg::REG_P2]);
    res = '0;
    if (fx == 0 || fy == 0) return res;
    px = longint'(d.out_col) << 16;
    py = longint'(d.out_row) << 16;
    // normalize to Q8.24
    y = clamp32(floor_quot((py - cy) << 24, fy));
    x = clamp32(floor_quot((px - cx) << 24, fx));
    x = clamp32(x - qmul(skew, y, 28));
    // radial terms
    xx = qmul(x, x, 24);
    yy = qmul(y, y, 24);
    xy = qmul(x, y, 24);
    r2 = clamp32(xx + yy);
    r4 = qmul(r2, r2, 24);
    r6 = qmul(r4, r2, 24);
    rad = clamp32((64'sd1 << 24) + qmul(k1, r2, 28) + qmul(k2, r4, 28) + qmul(k3, r6, 28));
    // tangential terms
    xd = clamp32(qmul(x, rad, 24) + 2 * qmul(p1, xy, 28)
                 + qmul(p2, clamp32(r2 + 2 * xx), 28));
    yd = clamp32(qmul(y, rad, 24) + qmul(p1, clamp32(r2 + 2 * yy), 28)
                 + 2 * qmul(p2, xy, 28));
    // back to pixels, then floor
    s = clamp32(xd + qmul(skew, yd, 28));
    u = ((fx * s) >>> 24) + cx;
    v = ((fy * yd) >>> 24) + cy;
    col = u >>> 16;
    row = v >>> 16;
    if (col >= 0 && row >= 0 && col < ldcm_pkg::DEF_IMAGE_WIDTH
        && row < ldcm_pkg::DEF_IMAGE_HEIGHT) begin
      res.src_col = col[9:0];
      res.src_row = row[8:0];
      res.in_range = 1'b1;
    end
    return res;
  endfunction

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lens_distortion_coordinate_map NOT OK");
      $finish;
    end
  end

  // Receiver stalls in bursts
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(1, 18);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    ldcm_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        fails++;
      end else begin
        want = pending_coords.pop_front();
        if (out_data.src_col !== want.src_col) begin
          $error("src_col expected %0d got %0d", want.src_col, out_data.src_col);
          fails++;
        end
        if (out_data.src_row !== want.src_row) begin
          $error("src_row expected %0d got %0d", want.src_row, out_data.src_row);
          fails++;
        end
        if (out_data.in_range !== want.in_range) begin
          $error("in_range expected %0d got %0d", want.in_range, out_data.in_range);
          fails++;
        end
      end
    end
  end

  // Drive one beat, hold until accepted, log its expectation, then sometimes pause
  task automatic push_pixel(int col, int row, bit fixed, ldcm_pkg::out_t want);
    ldcm_pkg::in_t d;
    int n;
    d.out_col = col[9:0];
    d.out_row = row[8:0];
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    pending_coords.push_back(fixed ? want : remap_pixel(d));
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Write one register and update its shadow copy
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reg[idx] = (idx >= ldcm_pkg::REG_SKEW) ? {32'd0, val[31:0]} : val;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] small_coeff();
    return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
  endfunction

  // Load one register setting
  task automatic load_setting(int kind);
    logic [63:0] v [8];
    case (kind)
      0: begin
        v[ldcm_pkg::REG_FOCAL] = {16'($urandom_range(300, 800)), 16'($urandom),
                                  16'($urandom_range(300, 800)), 16'($urandom)};
        v[ldcm_pkg::REG_PP] = {16'($urandom_range(280, 360)), 16'($urandom),
                               16'($urandom_range(200, 280)), 16'($urandom)};
        for (int i = 2; i < 8; i++) v[i] = {32'd0, small_coeff()};
      end
      1: begin
        v[ldcm_pkg::REG_FOCAL] = '1;
        v[ldcm_pkg::REG_PP] = '1;
        for (int i = 2; i < 8; i++) v[i] = 64'h0000_0000_7FFF_FFFF;
      end
      2: begin
        v[ldcm_pkg::REG_FOCAL] = 64'h0000_0001_0000_0001;
        v[ldcm_pkg::REG_PP] = '0;
        for (int i = 2; i < 8; i++) v[i] = 64'hFFFF_FFFF_8000_0000;
      end
      3: begin
        v[ldcm_pkg::REG_FOCAL] = {32'd0, $urandom()};
        v[ldcm_pkg::REG_PP] = {$urandom(), $urandom()};
        for (int i = 2; i < 8; i++) v[i] = {32'd0, small_coeff()};
      end
      4: begin
        v[ldcm_pkg::REG_FOCAL] = {$urandom(), 32'd0};
        v[ldcm_pkg::REG_PP] = {$urandom(), $urandom()};
        for (int i = 2; i < 8; i++) v[i] = {$urandom(), $urandom()};
      end
      default: begin
        for (int i = 0; i < 8; i++) v[i] = {$urandom(), $urandom()};
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        push_pixel($urandom_range(0, 1023), $urandom_range(0, 511), 1'b0, '0);
      end else begin
        push_pixel($urandom_range(0, 639), $urandom_range(0, 479), 1'b0, '0);
      end
    end
  endtask

  initial begin
    pix_row_t directed [$];
    int kinds [$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = ldcm_pkg::REG_FOCAL;
    cfg_wdata = '0;
    fails = 0;
    cycles = 0;
    quiet = 1'b0;
    for (int i = 0; i < 8; i++) shadow_reg[i] = '0;
    shadow_reg[ldcm_pkg::REG_FOCAL] = ldcm_pkg::FOCAL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting is the identity map, saturating beyond 127 pixels
    directed = '{
      '{0, 0, 1'b1, '{10'd0, 9'd0, 1'b1}},
      '{5, 3, 1'b1, '{10'd5, 9'd3, 1'b1}},
      '{127, 127, 1'b1, '{10'd127, 9'd127, 1'b1}},
      '{639, 479, 1'b1, '{10'd127, 9'd127, 1'b1}},
      '{1023, 511, 1'b1, '{10'd127, 9'd127, 1'b1}},
      '{1023, 0, 1'b1, '{10'd127, 9'd0, 1'b1}},
      '{0, 511, 1'b1, '{10'd0, 9'd127, 1'b1}},
      '{682, 341, 1'b0, '0},
      '{341, 170, 1'b0, '0},
      '{640, 480, 1'b0, '0}
    };
    foreach (directed[i])
      push_pixel(directed[i].col, directed[i].row, directed[i].fixed, directed[i].want);
    random_pixels(150);

    // Walk the settings: realistic lens, extremes, zero focal lengths, full random
    kinds = '{0, 1, 2, 3, 4, 5, 0};
    foreach (kinds[k]) begin
      drain_pipe();
      load_setting(kinds[k]);
      if (k == kinds.size() - 1) quiet = 1'b1;
      push_pixel(0, 0, 1'b0, '0);
      push_pixel(1023, 511, 1'b0, '0);
      random_pixels(180);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (fails == 0) begin
      $display("tb_lens_distortion_coordinate_map OK");
    end else begin
      $display("tb_lens_distortion_coordinate_map NOT OK");
    end
    $finish;
  end

endmodule
